[hw/rtl/skf_pkg.sv]
// Shared types, constants and microcode table of the scalar Kalman filter.
`timescale 1ns / 1ps
package skf_pkg;

	// Field widths
	localparam int MEAS_W  = 32;
	localparam int COV_W   = 32;
	localparam int NOISE_W = 31;
	localparam int GAIN_W  = 31;
	localparam int DEN_W   = 33;
	localparam int REM_W   = 34;
	localparam int PROD_W  = 64;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;
	localparam int STEP_W  = 4;
	localparam int DCNT_W  = 5;

	// Q2.30 constants
	localparam logic [GAIN_W-1:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [PROD_W-1:0] Q30_HALF = 64'h0000_0000_2000_0000;
	localparam logic [COV_W-1:0]  COV_RESET = 32'h4000_0000;
	localparam logic [NOISE_W-1:0] PN_RESET = 31'd1073742;
	localparam logic [NOISE_W-1:0] MN_RESET = 31'd10737418;

	// Index of the last divider step; the divider produces one quotient bit per step
	localparam logic [DCNT_W-1:0] DIV_LAST = 5'd30;

	// Register indexes (word address)
	localparam logic REG_PN = 1'b0;
	localparam logic REG_MN = 1'b1;

	// Datapath operations
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_PRED = 4'd2;
	localparam logic [3:0] OP_DEN  = 4'd3;
	localparam logic [3:0] OP_DIV  = 4'd4;
	localparam logic [3:0] OP_MULD = 4'd5;
	localparam logic [3:0] OP_EST  = 4'd6;
	localparam logic [3:0] OP_MULP = 4'd7;
	localparam logic [3:0] OP_COV  = 4'd8;
	localparam logic [3:0] OP_OUT  = 4'd9;

	// Branch conditions: true advances (or returns to S_LOAD when ret is set), false jumps to the target
	localparam logic [2:0] C_ALWAYS   = 3'd0;
	localparam logic [2:0] C_IN_VALID = 3'd1;
	localparam logic [2:0] C_DIV_DONE = 3'd2;
	localparam logic [2:0] C_OUT_FREE = 3'd3;
	localparam logic [2:0] C_NEVER    = 3'd4;

	// Program steps
	localparam logic [STEP_W-1:0] S_LOAD = 4'd0;
	localparam logic [STEP_W-1:0] S_PRED = 4'd1;
	localparam logic [STEP_W-1:0] S_DEN  = 4'd2;
	localparam logic [STEP_W-1:0] S_DIV  = 4'd3;
	localparam logic [STEP_W-1:0] S_MULD = 4'd4;
	localparam logic [STEP_W-1:0] S_EST  = 4'd5;
	localparam logic [STEP_W-1:0] S_MULP = 4'd6;
	localparam logic [STEP_W-1:0] S_COV  = 4'd7;
	localparam logic [STEP_W-1:0] S_OUT  = 4'd8;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        cond;
		logic              ret;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic div_done;
		logic out_free;
	} status_t;

	// Control store
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		begin
			case (step)
				S_LOAD:  w = '{op: OP_LOAD, cond: C_IN_VALID, ret: 1'b0, target: S_LOAD};
				S_PRED:  w = '{op: OP_PRED, cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_DEN:   w = '{op: OP_DEN,  cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_DIV:   w = '{op: OP_DIV,  cond: C_DIV_DONE, ret: 1'b0, target: S_DIV};
				S_MULD:  w = '{op: OP_MULD, cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_EST:   w = '{op: OP_EST,  cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_MULP:  w = '{op: OP_MULP, cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_COV:   w = '{op: OP_COV,  cond: C_ALWAYS,   ret: 1'b0, target: S_LOAD};
				S_OUT:   w = '{op: OP_OUT,  cond: C_OUT_FREE, ret: 1'b1, target: S_OUT};
				default: w = '{op: OP_NOP,  cond: C_NEVER,    ret: 1'b0, target: S_LOAD};
			endcase
			return w;
		end
	endfunction

endpackage

[hw/rtl/skf_meas_if.sv]
// Measurement channel: valid/ready handshake with one reading per beat.
`timescale 1ns / 1ps
interface skf_meas_if;
	import skf_pkg::*;
	logic              valid;
	logic              ready;
	logic [MEAS_W-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

[hw/rtl/skf_est_if.sv]
// Estimate channel: valid/ready handshake with one filtered estimate per beat.
`timescale 1ns / 1ps
interface skf_est_if;
	import skf_pkg::*;
	logic              valid;
	logic              ready;
	logic [MEAS_W-1:0] filtered_estimate;

	modport source (output valid, output filtered_estimate, input ready);
	modport sink (input valid, input filtered_estimate, output ready);
endinterface

[hw/rtl/skf_cfg.sv]
// APB register file holding the process and measurement noise.
`timescale 1ns / 1ps
module skf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [skf_pkg::CFG_AW-1:0]    paddr,
	input  logic [skf_pkg::CFG_DW-1:0]    pwdata,
	output logic [skf_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready,
	output logic [skf_pkg::NOISE_W-1:0]   pn,
	output logic [skf_pkg::NOISE_W-1:0]   mn
);
	import skf_pkg::*;

	logic [NOISE_W-1:0] pn_q;
	logic [NOISE_W-1:0] mn_q;
	logic               wr_en;

	// Word index is paddr[2]; byte offset bits are ignored
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= PN_RESET;
			mn_q <= MN_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_PN) begin
				pn_q <= pwdata[NOISE_W-1:0];
			end else begin
				mn_q <= pwdata[NOISE_W-1:0];
			end
		end
	end

	// Read back
	assign prdata = (paddr[2] == REG_MN) ? {1'b0, mn_q} : {1'b0, pn_q};
	assign pn     = pn_q;
	assign mn     = mn_q;
endmodule

[hw/rtl/skf_seq.sv]
// Microcode sequencer: step counter, control store and conditional branch.
`timescale 1ns / 1ps
module skf_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  skf_pkg::status_t status,
	output skf_pkg::ctrl_t   ctrl
);
	import skf_pkg::*;

	logic [STEP_W-1:0] step_q;
	ctrl_t             word;
	logic              cond_ok;

	assign word = ucode(step_q);
	assign ctrl = word;

	// Branch condition
	always_comb begin
		case (word.cond)
			C_ALWAYS:   cond_ok = 1'b1;
			C_IN_VALID: cond_ok = status.in_valid;
			C_DIV_DONE: cond_ok = status.div_done;
			C_OUT_FREE: cond_ok = status.out_free;
			default:    cond_ok = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_LOAD;
		end else if (cond_ok) begin
			step_q <= word.ret ? S_LOAD : step_q + STEP_W'(1);
		end else begin
			step_q <= word.target;
		end
	end
endmodule

[hw/rtl/skf_div.sv]
// Restoring divider for the gain, one quotient bit per step.
`timescale 1ns / 1ps
module skf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skf_pkg::ctrl_t              ctrl,
	input  logic [skf_pkg::COV_W-1:0]   dividend,
	input  logic [skf_pkg::DEN_W-1:0]   divisor,
	output logic [skf_pkg::GAIN_W-1:0]  quotient,
	output logic                        done
);
	import skf_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [GAIN_W-1:0] quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              dz_q;
	logic [REM_W-1:0]  shifted;
	logic [REM_W-1:0]  den_ext;
	logic              ge;
	logic              start;
	logic              step;

	assign start = (ctrl.op == OP_DEN);
	assign step  = (ctrl.op == OP_DIV);

	// First step compares p itself (quotient bit for 1.0), later steps shift
	assign shifted = (cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign den_ext = {1'b0, den_q};
	assign ge      = (shifted >= den_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + DCNT_W'(1);
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, dividend};
			den_q <= divisor;
			dz_q  <= (divisor == '0);
		end else if (step) begin
			rem_q <= ge ? (shifted - den_ext) : shifted;
			quo_q <= {quo_q[GAIN_W-2:0], ge};
		end
	end

	// Zero denominator gives a gain of exactly one
	assign quotient = dz_q ? Q30_ONE : quo_q;
	assign done     = step && (cnt_q == DIV_LAST);
endmodule

[hw/rtl/skf_dp.sv]
// Filter datapath: state, shared multiplier, estimate and covariance update.
`timescale 1ns / 1ps
module skf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skf_pkg::ctrl_t              ctrl,
	skf_meas_if.sink                    meas,
	skf_est_if.source                   filt,
	input  logic [skf_pkg::NOISE_W-1:0] pn,
	input  logic [skf_pkg::NOISE_W-1:0] mn,
	input  logic [skf_pkg::GAIN_W-1:0]  gain,
	output logic [skf_pkg::COV_W-1:0]   dividend,
	output logic [skf_pkg::DEN_W-1:0]   divisor,
	output logic                        out_free
);
	import skf_pkg::*;

	logic [MEAS_W-1:0] est_q;
	logic [COV_W-1:0]  cov_q;
	logic [MEAS_W-1:0] z_q;
	logic [COV_W-1:0]  p_q;
	logic [MEAS_W-1:0] dist_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic [MEAS_W-1:0] out_q;
	logic              out_valid_q;

	logic [DEN_W-1:0]  pred_sum;
	logic [COV_W-1:0]  pred_sat;
	logic              z_lt;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [PROD_W-1:0] rnd;
	logic [MEAS_W-1:0] step_amt;
	logic              load_in;
	logic              load_out;

	assign meas.ready = (ctrl.op == OP_LOAD);
	assign load_in    = meas.valid && meas.ready;

	// Prediction with saturation
	assign pred_sum = {1'b0, cov_q} + {2'b00, pn};
	assign pred_sat = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
	assign z_lt     = (z_q < est_q);

	// Gain denominator, exact in 33 bits
	assign dividend = p_q;
	assign divisor  = {1'b0, p_q} + {2'b00, mn};

	// Shared multiplier operands
	always_comb begin
		case (ctrl.op)
			OP_MULD: begin
				mul_a = dist_q;
				mul_b = {1'b0, gain};
			end
			OP_MULP: begin
				mul_a = p_q;
				mul_b = {1'b0, Q30_ONE - gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round half up and drop 30 fraction bits
	assign rnd      = prod_q + Q30_HALF;
	assign step_amt = rnd[61:30];

	// Working registers
	always_ff @(posedge clk) begin
		if (load_in) begin
			z_q <= meas.measurement;
		end
		if (ctrl.op == OP_PRED) begin
			p_q    <= pred_sat;
			neg_q  <= z_lt;
			dist_q <= z_lt ? (est_q - z_q) : (z_q - est_q);
		end
		if (ctrl.op == OP_MULD || ctrl.op == OP_MULP) begin
			prod_q <= mul_a * mul_b;
		end
		if (load_out) begin
			out_q <= est_q;
		end
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= COV_RESET;
		end else begin
			if (ctrl.op == OP_EST) begin
				est_q <= neg_q ? (est_q - step_amt) : (est_q + step_amt);
			end
			if (ctrl.op == OP_COV) begin
				cov_q <= step_amt;
			end
		end
	end

	// Output register
	assign out_free = !out_valid_q || filt.ready;
	assign load_out = (ctrl.op == OP_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (filt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign filt.valid             = out_valid_q;
	assign filt.filtered_estimate = out_q;
endmodule

[hw/rtl/scalar_kalman_filter.sv]
// Scalar Kalman filter top level: sequencer, datapath, divider and registers.
// One measurement at a time: the next measurement beat is accepted only once the estimate
// of the previous one has been loaded into the output register, which waits while results
// are not taken. The 31-step gain divider, one quotient bit per cycle, takes most of each
// update.
// Reset (arst_n low) clears estimate to 0, sets covariance to 1.0 and noise to defaults.
`timescale 1ns / 1ps
module scalar_kalman_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	skf_meas_if.sink                    meas,
	skf_est_if.source                   filt,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skf_pkg::CFG_AW-1:0]  paddr,
	input  logic [skf_pkg::CFG_DW-1:0]  pwdata,
	output logic [skf_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready
);
	import skf_pkg::*;

	ctrl_t              ctrl;
	status_t            status;
	logic [NOISE_W-1:0] pn;
	logic [NOISE_W-1:0] mn;
	logic [GAIN_W-1:0]  gain;
	logic [COV_W-1:0]   dividend;
	logic [DEN_W-1:0]   divisor;
	logic               div_done;
	logic               out_free;

	assign status.in_valid = meas.valid;
	assign status.div_done = div_done;
	assign status.out_free = out_free;

	skf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pn      (pn),
		.mn      (mn)
	);

	skf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	skf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (gain),
		.done     (div_done)
	);

	skf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.meas     (meas),
		.filt     (filt),
		.pn       (pn),
		.mn       (mn),
		.gain     (gain),
		.dividend (dividend),
		.divisor  (divisor),
		.out_free (out_free)
	);
endmodule

[hw/rtl/skf_chk.sv]
// Port-level checker for the scalar Kalman filter, bound to the top level.
`timescale 1ns / 1ps
module skf_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        meas_valid,
	input logic                        meas_ready,
	input logic                        filt_valid,
	input logic                        filt_ready,
	input logic [skf_pkg::MEAS_W-1:0]  filt_estimate
);
	import skf_pkg::*;

	logic meas_beat;
	assign meas_beat = meas_valid && meas_ready;

	// One measurement in flight: no second beat right after a first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		meas_beat |=> !meas_ready)
		else $error("measurement accepted while previous one in progress");

	// An estimate needs the whole update; none appears just after a beat
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		meas_beat |=> !$rose(filt_valid) ##1 !$rose(filt_valid))
		else $error("estimate appeared too soon after a measurement");

	// Loading a result returns the sequencer to the input wait
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filt_valid) |-> meas_ready)
		else $error("not ready for a measurement once the estimate is posted");

	// Stalled estimate beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		filt_valid && !filt_ready |=> filt_valid && $stable(filt_estimate))
		else $error("estimate dropped or changed while stalled");
endmodule

bind scalar_kalman_filter skf_chk u_skf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.meas_valid    (meas.valid),
	.meas_ready    (meas.ready),
	.filt_valid    (filt.valid),
	.filt_ready    (filt.ready),
	.filt_estimate (filt.filtered_estimate)
);

[tb/scalar_kalman_filter_tb.sv]
// Self-checking testbench of the scalar Kalman filter: directed and random readings.
`timescale 1ns / 1ps
module scalar_kalman_filter_tb;
	import skf_pkg::*;

	localparam int GAIN_FRAC      = 30;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_READINGS = 118;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	skf_meas_if meas_bus ();
	skf_est_if  est_bus ();

	scalar_kalman_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.meas    (meas_bus),
		.filt    (est_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Filter state as predicted by the testbench
	logic [COV_W-1:0]   cov_st;
	logic [MEAS_W-1:0]  est_st;
	logic [NOISE_W-1:0] pn_st;
	logic [NOISE_W-1:0] mn_st;

	logic [MEAS_W-1:0] pending_estimates[$];
	logic [MEAS_W-1:0] reading_base;
	int                mismatch_count;
	int                idle_cycles;
	bit                idle_on;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One filter step on the predicted state; returns the expected estimate
	function automatic logic [MEAS_W-1:0] next_estimate(input logic [MEAS_W-1:0] z);
		logic [32:0] sum;
		logic [31:0] p;
		logic [63:0] den;
		logic [63:0] gain;
		logic [63:0] offset;
		logic [63:0] q;
		sum = {1'b0, cov_st} + {2'b00, pn_st};
		p = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		den = 64'(p) + 64'(mn_st);
		// zero denominator gives a gain of exactly one
		gain = (den == 64'd0) ? 64'(Q30_ONE) : ((64'(p) << GAIN_FRAC) / den);
		if (z >= est_st) begin
			offset = 64'(z - est_st);
			q = (offset * gain + Q30_HALF) >> GAIN_FRAC;
			est_st = est_st + q[31:0];
		end else begin
			offset = 64'(est_st - z);
			q = (offset * gain + Q30_HALF) >> GAIN_FRAC;
			est_st = est_st - q[31:0];
		end
		cov_st = 32'((64'(p) * (64'(Q30_ONE) - gain) + Q30_HALF) >> GAIN_FRAC);
		return est_st;
	endfunction

	task automatic report_mismatch(input string what, input logic [MEAS_W-1:0] exp_val,
			input logic [MEAS_W-1:0] got_val);
		$display("%0t ns: %s: expected %h, got %h", $time, what, exp_val, got_val);
		mismatch_count++;
	endtask

	// Send one measurement beat after a random gap when idling is on, predict on acceptance
	task automatic send_reading(input logic [MEAS_W-1:0] z);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			@(negedge clk) meas_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		meas_bus.valid <= 1'b1;
		meas_bus.measurement <= z;
		do @(posedge clk); while (!meas_bus.ready);
		pending_estimates.push_back(next_estimate(z));
	endtask

	// Stop sending and wait until every estimate has come back
	task automatic drain_estimates();
		@(negedge clk) meas_bus.valid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// APB write: setup then access phase
	task automatic write_noise_reg(input logic idx, input logic [CFG_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_PN)
			pn_st = value[NOISE_W-1:0];
		else
			mn_st = value[NOISE_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [CFG_DW-1:0] random_noise();
		logic [CFG_DW-1:0] v;
		case ($urandom_range(0, 5))
			0:       v = '0;
			1:       v = 32'(Q30_ONE);
			2:       v = 32'h7FFF_FFFF;
			3:       v = $urandom_range(0, 1 << 24);
			4:       v = $urandom & 32'h7FFF_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly a steady tone with jitter, some wild readings and jumps
	function automatic logic [MEAS_W-1:0] random_reading();
		int                r;
		logic [MEAS_W-1:0] jitter;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			jitter = $urandom_range(0, 1 << $urandom_range(4, 20));
			return $urandom_range(0, 1) ? reading_base + jitter : reading_base - jitter;
		end else if (r < 85) begin
			return $urandom;
		end else if (r < 92) begin
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		end
		reading_base = $urandom;
		return reading_base;
	endfunction

	// Estimate sink: random stalls when idling is on, checks every beat against the oldest prediction
	initial begin
		int                stall;
		logic [MEAS_W-1:0] want;
		est_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				@(negedge clk) est_bus.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) est_bus.ready <= 1'b1;
			do @(posedge clk); while (!(est_bus.valid && est_bus.ready));
			if (pending_estimates.size() == 0) begin
				report_mismatch("unexpected estimate beat", 'x, est_bus.filtered_estimate);
			end else begin
				want = pending_estimates.pop_front();
				if (est_bus.filtered_estimate !== want)
					report_mismatch("filtered_estimate", want, est_bus.filtered_estimate);
			end
		end
	end

	// Watchdog on cycles with no beat on any port
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((meas_bus.valid && meas_bus.ready) || (est_bus.valid && est_bus.ready) ||
					(psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Reset configuration, tone extremes
	task automatic test_reset_defaults();
		send_reading(32'h0000_0000);
		send_reading(32'hFFFF_FFFF);
		send_reading(32'hAAAA_5555);
		send_reading(32'h0000_0001);
		drain_estimates();
	endtask

	// Both noises zero: gain of one, then a zero denominator
	task automatic test_zero_denominator();
		write_noise_reg(REG_PN, 32'h0);
		write_noise_reg(REG_MN, 32'h0);
		send_reading(32'h1234_5678);
		send_reading(32'hFFFF_FFFF);
		send_reading(32'h0000_0000);
		drain_estimates();
	endtask

	// Top bit of a write is dropped
	task automatic test_register_masking();
		write_noise_reg(REG_PN, 32'hFFFF_FFFF);
		write_noise_reg(REG_MN, 32'h8000_0001);
		send_reading(32'h8000_0000);
		send_reading(32'h0000_0000);
		send_reading(32'h7FFF_FFFF);
		drain_estimates();
	endtask

	// Corners of the noise range
	task automatic test_noise_extremes();
		logic [CFG_DW-1:0] pn_set[3];
		logic [CFG_DW-1:0] mn_set[3];
		pn_set = '{32'(Q30_ONE), 32'h0, 32'h7FFF_FFFF};
		mn_set = '{32'h1, 32'(Q30_ONE), 32'h7FFF_FFFF};
		for (int i = 0; i < 3; i++) begin
			write_noise_reg(REG_PN, pn_set[i]);
			write_noise_reg(REG_MN, mn_set[i]);
			send_reading(32'hFFFF_FFFF);
			send_reading(32'h0000_0000);
			send_reading(32'h5555_AAAA);
			drain_estimates();
		end
	endtask

	// Random readings under several noise settings, idling on and off
	task automatic test_random_streams();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_on = (ph % 3 != 2);
			if (ph == 0) begin
				write_noise_reg(REG_PN, 32'h0);
				write_noise_reg(REG_MN, 32'h1);
			end else if (ph == RANDOM_PHASES - 1) begin
				write_noise_reg(REG_PN, 32'h7FFF_FFFF);
				write_noise_reg(REG_MN, 32'(Q30_ONE));
			end else begin
				write_noise_reg(REG_PN, random_noise());
				write_noise_reg(REG_MN, random_noise());
			end
			reading_base = $urandom;
			for (int n = 0; n < PHASE_READINGS; n++) begin
				// hold off mid-phase until the pipeline is empty
				if (n == PHASE_READINGS / 2)
					drain_estimates();
				send_reading(random_reading());
			end
			drain_estimates();
		end
	endtask

	// Main sequence
	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		meas_bus.valid       = 1'b0;
		meas_bus.measurement = '0;
		mismatch_count       = 0;
		idle_on              = 1'b1;
		reading_base         = '0;
		cov_st               = COV_RESET;
		est_st               = '0;
		pn_st                = PN_RESET;
		mn_st                = MN_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_defaults();
		test_zero_denominator();
		test_register_masking();
		test_noise_extremes();
		test_random_streams();

		drain_estimates();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/skf_pkg.sv
hw/rtl/skf_meas_if.sv
hw/rtl/skf_est_if.sv
hw/rtl/skf_cfg.sv
hw/rtl/skf_seq.sv
hw/rtl/skf_div.sv
hw/rtl/skf_dp.sv
hw/rtl/scalar_kalman_filter.sv
hw/rtl/skf_chk.sv
tb/scalar_kalman_filter_tb.sv
